/* sv/bdta_pkg.sv */
package bdta_pkg;

    localparam int MAX_COLS    = 256;
    localparam int MAX_TILE    = 64;
    localparam int PALETTE_LEN = 68;
    localparam int ROM_LEN     = 68;

    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int TILE_W     = $clog2(MAX_TILE);
    localparam int SUM_W      = 20;
    localparam int CFG_TILE_W = 7;
    localparam int CFG_COLS_W = 9;
    localparam int DIVISOR_W  = 13;
    localparam int MEAN_W     = 8;
    localparam int STEP_W     = 4;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [1:0] REG_BLOCK_W  = 2'd0;
    localparam logic [1:0] REG_BLOCK_H  = 2'd1;
    localparam logic [1:0] REG_OUT_COLS = 2'd2;

    localparam logic [CFG_TILE_W-1:0] BLOCK_W_RST  = 7'd4;
    localparam logic [CFG_TILE_W-1:0] BLOCK_H_RST  = 7'd8;
    localparam logic [CFG_COLS_W-1:0] OUT_COLS_RST = 9'd80;

    localparam logic [8*ROM_LEN-1:0] CHAR_ROM =
        "@B%8&WM#*oahkbdpqwmZO0QLCJUYXzcvunxrjft/|()1{}[]?-_+~<>i!lI;:,\" ^'. ";

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } t_pix_word;

    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } t_char_word;

    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_addr;
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
        logic [SUM_W-1:0] wr_data;
    } t_mem_req;

    typedef struct packed {
        logic                 start;
        logic [SUM_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [MEAN_W-1:0] mean;
    } t_div_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_EMIT
    } t_state;

    function automatic logic [7:0] palette_char(input logic [MEAN_W-1:0] mean);
        logic [14:0] prod;
        logic [6:0]  idx;
        prod = {7'd0, mean} * 15'(PALETTE_LEN);
        idx  = prod[14:8];
        if (idx >= 7'(ROM_LEN)) begin
            idx = 7'(ROM_LEN - 1);
        end
        return CHAR_ROM[8*(ROM_LEN-1-int'(idx)) +: 8];
    endfunction

endpackage

/* sv/bdta_mem.sv */
module bdta_mem (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bdta_pkg::t_mem_req               i_req,
    output logic [bdta_pkg::SUM_W-1:0]       o_rd_data
);
    import bdta_pkg::*;

    logic [SUM_W-1:0]    r_mem [MAX_COLS];
    logic [MAX_COLS-1:0] r_valid;
    logic [SUM_W-1:0]    r_rd_data;
    logic                r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

/* sv/bdta_div.sv */
module bdta_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bdta_pkg::t_div_req i_req,
    output bdta_pkg::t_div_rsp o_rsp
);
    import bdta_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_W-1:0]    r_step;
    logic [SUM_W-1:0]     r_rem;
    logic [DIVISOR_W-1:0] r_div;
    logic [MEAN_W-1:0]    r_quo;
    logic                 r_sat;
    logic [MEAN_W-1:0]    r_mean;

    logic [SUM_W:0]       w_shift;
    logic                 w_ge;
    logic                 w_top;
    logic [MEAN_W-1:0]    w_quo_next;

    always_comb begin
        w_shift    = {{(SUM_W+1-DIVISOR_W){1'b0}}, r_div} << r_step;
        w_ge       = {1'b0, r_rem} >= w_shift;
        w_top      = r_step == STEP_W'(MEAN_W);
        w_quo_next = r_quo;
        if (!w_top && w_ge) begin
            w_quo_next[r_step[2:0]] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(MEAN_W);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    // restoring division, top step only detects a quotient above 255
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend;
            r_div <= i_req.divisor;
            r_quo <= '0;
            r_sat <= 1'b0;
        end else if (r_busy) begin
            if (w_top) begin
                r_sat <= w_ge;
            end else if (w_ge) begin
                r_rem <= r_rem - w_shift[SUM_W-1:0];
            end
            r_quo <= w_quo_next;
            if (r_step == '0) begin
                r_mean <= r_sat ? '1 : w_quo_next;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.mean = r_mean;

endmodule

/* sv/box_downscale_to_ascii.sv */
// channel   direction  word          handshake
// in        input      t_pix_word    i_in_valid / o_in_ready
// out       output     t_char_word   o_out_valid / i_out_ready
// cfg       input      apb regs      psel / penable / pwrite, pready tied high
//
// one pixel at a time: a pixel that completes no tile is read and written back; a
// tile's last pixel: read, write back, 9 divider steps, divider done, result load
// the divider steps one quotient bit per cycle; the tile sums sit in a registered-read memory
// a new pixel is taken while a finished character waits in the output register
// synchronous active-low reset zeroes counters and sums and loads register defaults
// a stalled output holds the last pixel's character back until it is taken
module box_downscale_to_ascii (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bdta_pkg::ADDR_W-1:0]       paddr,
    input  logic [bdta_pkg::DATA_W-1:0]       pwdata,
    output logic [bdta_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  bdta_pkg::t_pix_word               i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output bdta_pkg::t_char_word              o_out_word
);
    import bdta_pkg::*;

    logic [CFG_TILE_W-1:0] r_block_w;
    logic [CFG_TILE_W-1:0] r_block_h;
    logic [CFG_COLS_W-1:0] r_out_cols;

    t_state            r_state;
    t_state            n_state;
    logic [COL_W-1:0]  r_col;
    logic [TILE_W-1:0] r_x;
    logic [TILE_W-1:0] r_row;
    logic [7:0]        r_pix;
    logic              r_line_end;
    logic              r_out_valid;
    t_char_word        r_out_word;

    logic [CFG_TILE_W-1:0] w_bw;
    logic [CFG_TILE_W-1:0] w_bh;
    logic [CFG_COLS_W-1:0] w_cols;
    logic                  w_last_x;
    logic                  w_last_col;
    logic                  w_last_row;
    logic                  w_emit;
    logic                  w_in_acc;
    logic                  w_cfg_wr;
    logic                  w_out_load;
    logic [SUM_W-1:0]      w_rd_data;
    logic [SUM_W-1:0]      w_sum;
    t_mem_req              w_mem_req;
    t_div_req              w_div_req;
    t_div_rsp              w_div_rsp;

    // config port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_w  <= BLOCK_W_RST;
            r_block_h  <= BLOCK_H_RST;
            r_out_cols <= OUT_COLS_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_BLOCK_W:  r_block_w  <= pwdata[CFG_TILE_W-1:0];
                REG_BLOCK_H:  r_block_h  <= pwdata[CFG_TILE_W-1:0];
                REG_OUT_COLS: r_out_cols <= pwdata[CFG_COLS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BLOCK_W:  prdata = {{(DATA_W-CFG_TILE_W){1'b0}}, r_block_w};
            REG_BLOCK_H:  prdata = {{(DATA_W-CFG_TILE_W){1'b0}}, r_block_h};
            REG_OUT_COLS: prdata = {{(DATA_W-CFG_COLS_W){1'b0}}, r_out_cols};
            default:      prdata = '0;
        endcase
    end

    // saturated tile and line sizes
    always_comb begin
        priority if (r_block_w == '0) begin
            w_bw = CFG_TILE_W'(1);
        end else if (r_block_w > CFG_TILE_W'(MAX_TILE)) begin
            w_bw = CFG_TILE_W'(MAX_TILE);
        end else begin
            w_bw = r_block_w;
        end
        priority if (r_block_h == '0) begin
            w_bh = CFG_TILE_W'(1);
        end else if (r_block_h > CFG_TILE_W'(MAX_TILE)) begin
            w_bh = CFG_TILE_W'(MAX_TILE);
        end else begin
            w_bh = r_block_h;
        end
        priority if (r_out_cols == '0) begin
            w_cols = CFG_COLS_W'(1);
        end else if (r_out_cols > CFG_COLS_W'(MAX_COLS)) begin
            w_cols = CFG_COLS_W'(MAX_COLS);
        end else begin
            w_cols = r_out_cols;
        end
    end

    always_comb begin
        w_last_x   = ({1'b0, r_x} + 1'b1) >= w_bw;
        w_last_row = ({1'b0, r_row} + 1'b1) >= w_bh;
        w_last_col = ({{(CFG_COLS_W-COL_W){1'b0}}, r_col} + 1'b1) >= w_cols;
        w_emit     = w_last_x && w_last_row;
        if ((r_row == '0) && (r_x == '0)) begin
            w_sum = {{(SUM_W-8){1'b0}}, r_pix};
        end else begin
            w_sum = w_rd_data + {{(SUM_W-8){1'b0}}, r_pix};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = w_emit ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready         = r_state == S_IDLE;
        w_in_acc           = i_in_valid && o_in_ready;
        w_out_load         = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
        w_mem_req.rd_en    = w_in_acc;
        w_mem_req.rd_addr  = i_in_word.frame_start ? '0 : r_col;
        w_mem_req.wr_en    = r_state == S_READ;
        w_mem_req.wr_addr  = r_col;
        w_mem_req.wr_data  = w_sum;
        w_div_req.start    = (r_state == S_READ) && w_emit;
        w_div_req.dividend = w_sum;
        w_div_req.divisor  = {{(DIVISOR_W-CFG_TILE_W){1'b0}}, w_bw}
                           * {{(DIVISOR_W-CFG_TILE_W){1'b0}}, w_bh};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_x         <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc && i_in_word.frame_start) begin
                r_col <= '0;
                r_x   <= '0;
                r_row <= '0;
            end else if (r_state == S_READ) begin
                if (w_last_x) begin
                    r_x <= '0;
                    if (w_last_col) begin
                        r_col <= '0;
                        r_row <= w_last_row ? '0 : r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end else begin
                    r_x <= r_x + 1'b1;
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pix <= i_in_word.pixel;
        end
        if (r_state == S_READ) begin
            r_line_end <= w_last_col;
        end
        if (w_out_load) begin
            r_out_word.char_code <= palette_char(w_div_rsp.mean);
            r_out_word.line_end  <= r_line_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    bdta_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_mem_req),
        .o_rd_data (w_rd_data)
    );

    bdta_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    a_done_in_div : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> r_state == S_DIV)
        else $error("divider result outside divide phase");

    a_wr_after_rd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_req.wr_en |-> $past(w_mem_req.rd_en))
        else $error("sum write without preceding read");

    a_acc_to_read : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state == S_READ)
        else $error("accepted word not read from sum memory");

    a_load_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> o_out_valid)
        else $error("loaded character not presented");

endmodule

/* test/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bdta_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 1300;

    typedef enum int {
        PIX_RANDOM,
        PIX_FULL,
        PIX_ZERO,
        PIX_LEVEL
    } t_pix_mode;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } t_rx_mode;

    typedef struct packed {
        logic [7:0] pix;
        logic       fs;
        logic       typed;
        logic [7:0] code;
        logic       le;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    t_pix_word           i_in_word = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_char_word          o_out_word;

    box_downscale_to_ascii dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always #5 i_clk = ~i_clk;

    // character lookup, dark to light
    string glyphs = "@B%8&WM#*oahkbdpqwmZO0QLCJUYXzcvunxrjft/|()1{}[]?-_+~<>i!lI;:,\" ^'. ";

    logic [SUM_W-1:0]      col_sums [MAX_COLS] = '{default: '0};
    int                    tile_col = 0;
    int                    tile_x = 0;
    int                    tile_row = 0;
    logic [CFG_TILE_W-1:0] cfg_block_w = BLOCK_W_RST;
    logic [CFG_TILE_W-1:0] cfg_block_h = BLOCK_H_RST;
    logic [CFG_COLS_W-1:0] cfg_out_cols = OUT_COLS_RST;

    t_char_word pending_chars [$];
    int         n_fail = 0;
    int         n_random = 0;
    int         burst_left = 0;
    int         pix_level = 128;
    int         hold_seq = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    int         rx_left = 0;
    t_rx_mode   rx_mode = RX_OPEN;
    int         stall_cycles = 0;

    // frame start, back-to-back frame starts and the grey extremes
    t_dir_row dir_rows [15] = '{
        '{8'h00, 1'b1, 1'b1, "@", 1'b0},
        '{8'hff, 1'b0, 1'b1, " ", 1'b0},
        '{8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hff, 1'b0, 1'b1, " ", 1'b0},
        '{8'h00, 1'b0, 1'b1, "@", 1'b0},
        '{8'h55, 1'b1, 1'b0, 8'h00, 1'b0},
        '{8'haa, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h01, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hfe, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h7f, 1'b1, 1'b0, 8'h00, 1'b0},
        '{8'h80, 1'b1, 1'b0, 8'h00, 1'b0},
        '{8'h33, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hcc, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h0f, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hf0, 1'b0, 1'b0, 8'h00, 1'b0}
    };

    function automatic void note_fail(input string msg);
        n_fail++;
        if (n_fail <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function automatic int clamp_cfg(input int v, input int hi);
        if (v < 1) begin
            return 1;
        end
        return (v > hi) ? hi : v;
    endfunction

    function automatic void predict_tile_char(input t_pix_word w, output bit emits,
                                              output t_char_word ch);
        int bw;
        int bh;
        int cols;
        int c;
        int mean;
        int idx;
        bit last_x;
        bit last_col;
        bit last_row;
        bw = clamp_cfg(int'(cfg_block_w), MAX_TILE);
        bh = clamp_cfg(int'(cfg_block_h), MAX_TILE);
        cols = clamp_cfg(int'(cfg_out_cols), MAX_COLS);
        emits = 1'b0;
        ch = '0;
        if (w.frame_start) begin
            tile_col = 0;
            tile_x = 0;
            tile_row = 0;
        end
        c = tile_col;
        if (tile_row == 0 && tile_x == 0) begin
            col_sums[c] = SUM_W'(w.pixel);
        end else begin
            col_sums[c] = col_sums[c] + SUM_W'(w.pixel);
        end
        last_x = tile_x + 1 >= bw;
        last_col = c + 1 >= cols;
        last_row = tile_row + 1 >= bh;
        if (last_x && last_row) begin
            mean = int'(col_sums[c]) / (bw * bh);
            if (mean > 255) begin
                mean = 255;
            end
            idx = (mean * PALETTE_LEN) >> 8;
            if (idx >= ROM_LEN) begin
                idx = ROM_LEN - 1;
            end
            emits = 1'b1;
            ch.char_code = glyphs[idx];
            ch.line_end = last_col;
        end
        if (last_x) begin
            tile_x = 0;
            if (last_col) begin
                tile_col = 0;
                tile_row = last_row ? 0 : tile_row + 1;
            end else begin
                tile_col = c + 1;
            end
        end else begin
            tile_x = tile_x + 1;
        end
    endfunction

    function automatic logic [7:0] next_pixel(input t_pix_mode mode);
        int v;
        case (mode)
            PIX_FULL: begin
                return 8'hff;
            end
            PIX_ZERO: begin
                return 8'h00;
            end
            PIX_LEVEL: begin
                if ($urandom_range(0, 7) == 0) begin
                    pix_level = $urandom_range(0, 255);
                end
                v = pix_level + int'($urandom_range(0, 15)) - 8;
                v = (v < 0) ? 0 : ((v > 255) ? 255 : v);
                return 8'(v);
            end
            default: begin
                return 8'($urandom_range(0, 255));
            end
        endcase
    endfunction

    task automatic apb_access(input logic [1:0] regi, input logic wr, input logic [31:0] data,
                              output logic [31:0] rd);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {regi, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(input logic [1:0] regi, input int value);
        logic [31:0] rd;
        logic [31:0] mask;
        mask = (regi == REG_OUT_COLS) ? 32'h1ff : 32'h7f;
        apb_access(regi, 1'b0, $urandom, rd);
        if ((rd & mask) !== (32'(value) & mask)) begin
            note_fail($sformatf("register %0d reads %h, expected %h", regi, rd & mask,
                                32'(value) & mask));
        end
    endtask

    task automatic write_reg(input logic [1:0] regi, input int value);
        logic [31:0] rd;
        logic [31:0] mask;
        mask = (regi == REG_OUT_COLS) ? 32'h1ff : 32'h7f;
        apb_access(regi, 1'b1, ($urandom & ~mask) | (32'(value) & mask), rd);
        case (regi)
            REG_BLOCK_W: begin
                cfg_block_w = CFG_TILE_W'(value);
            end
            REG_BLOCK_H: begin
                cfg_block_h = CFG_TILE_W'(value);
            end
            default: begin
                cfg_out_cols = CFG_COLS_W'(value);
            end
        endcase
        check_reg(regi, value);
    endtask

    task automatic drain_chars();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_chars.size() != 0);
    endtask

    task automatic send_pixel(input t_pix_word w, input bit typed, input t_char_word typed_ch);
        int gap;
        bit emits;
        t_char_word ch;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (!o_in_ready);
        predict_tile_char(w, emits, ch);
        if (typed) begin
            pending_chars.push_back(typed_ch);
        end else if (emits) begin
            pending_chars.push_back(ch);
        end
    endtask

    task automatic run_phase(input int bw, input int bh, input int cols, input int n,
                             input bit fs_first, input t_pix_mode mode, input bit mid_pause,
                             input bit hold);
        t_pix_word w;
        drain_chars();
        repeat (20) @(posedge i_clk);
        write_reg(REG_BLOCK_W, bw);
        write_reg(REG_BLOCK_H, bh);
        write_reg(REG_OUT_COLS, cols);
        if (hold) begin
            hold_seq <= hold_seq + 1;
        end
        for (int i = 0; i < n; i++) begin
            if (mid_pause && i == n / 2 && i > 0) begin
                drain_chars();
            end
            w.pixel = next_pixel(mode);
            w.frame_start = (i == 0) ? fs_first : ($urandom_range(0, 63) == 0);
            send_pixel(w, 1'b0, '0);
        end
        n_random += n;
    endtask

    // output side: checks each word and stalls on its own pattern
    always @(posedge i_clk) begin
        t_char_word exp_ch;
        bit rdy;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_chars.size() == 0) begin
                    note_fail($sformatf("unexpected char %h line_end %b",
                                        o_out_word.char_code, o_out_word.line_end));
                end else begin
                    exp_ch = pending_chars.pop_front();
                    if (o_out_word.char_code !== exp_ch.char_code
                        || o_out_word.line_end !== exp_ch.line_end) begin
                        note_fail($sformatf("char mismatch: expected %h/%b got %h/%b",
                                            exp_ch.char_code, exp_ch.line_end,
                                            o_out_word.char_code, o_out_word.line_end));
                    end
                end
            end
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 128);
            end
            rx_left--;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN: begin
                        rdy = 1'b1;
                    end
                    RX_COIN: begin
                        rdy = 1'($urandom_range(0, 1));
                    end
                    RX_SPARSE: begin
                        rdy = (rx_left % 4 == 0);
                    end
                    default: begin
                        rdy = ($urandom_range(0, 7) != 0);
                    end
                endcase
            end
            i_out_ready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("box_downscale_to_ascii verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_pix_word w;
        t_char_word tch;
        int bw;
        int bh;
        int cols;
        int n;
        bit well;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_reg(REG_BLOCK_W, int'(BLOCK_W_RST));
        check_reg(REG_BLOCK_H, int'(BLOCK_H_RST));
        check_reg(REG_OUT_COLS, int'(OUT_COLS_RST));

        // one pixel per character, three characters per line
        write_reg(REG_BLOCK_W, 1);
        write_reg(REG_BLOCK_H, 1);
        write_reg(REG_OUT_COLS, 3);
        foreach (dir_rows[i]) begin
            w.pixel = dir_rows[i].pix;
            w.frame_start = dir_rows[i].fs;
            tch.char_code = dir_rows[i].code;
            tch.line_end = dir_rows[i].le;
            send_pixel(w, dir_rows[i].typed, tch);
        end

        // register extremes, out of range values and a mid-frame change
        run_phase(0, 1, 511, 256, 1'b1, PIX_LEVEL, 1'b0, 1'b1);
        run_phase(64, 2, 1, 128, 1'b1, PIX_FULL, 1'b1, 1'b0);
        run_phase(127, 0, 2, 128, 1'b1, PIX_ZERO, 1'b0, 1'b0);
        run_phase(1, 64, 0, 64, 1'b1, PIX_RANDOM, 1'b0, 1'b0);
        run_phase(1, 1, 256, 40, 1'b1, PIX_LEVEL, 1'b0, 1'b0);
        run_phase(2, 4, 1, 4, 1'b1, PIX_FULL, 1'b0, 1'b0);
        run_phase(2, 1, 1, 2, 1'b0, PIX_FULL, 1'b0, 1'b0);

        while (n_random < RANDOM_ITEMS) begin
            bw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 4);
            bh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 4);
            cols = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 8);
            well = ($urandom_range(0, 3) != 0);
            if (well) begin
                n = $urandom_range(1, 3) * clamp_cfg(bw, MAX_TILE) * clamp_cfg(bh, MAX_TILE)
                    * clamp_cfg(cols, MAX_COLS);
                if (n > 300) begin
                    n = $urandom_range(20, 300);
                end
            end else begin
                n = $urandom_range(1, 40);
            end
            run_phase(bw, bh, cols, n, well, t_pix_mode'($urandom_range(0, 3)),
                      $urandom_range(0, 15) == 0, 1'b0);
        end

        drain_chars();
        repeat (40) @(posedge i_clk);
        if (n_fail == 0 && pending_chars.size() == 0) begin
            $display("box_downscale_to_ascii verification clean");
        end else begin
            $display("box_downscale_to_ascii verification failed");
        end
        $finish;
    end

endmodule
